[rtl/fhlm_pkg.sv]
// shared types and constants for the queued lock manager
package fhlm_pkg;

	// fixed field widths of the request and result items
	localparam int TASK_W   = 8;
	localparam int STATUS_W = 3;

	// defaults for the top level parameters
	localparam int DEF_WAITER_DEPTH = 16;
	localparam int DEF_TASK_ID_BITS = 8;

	// request kinds
	localparam logic OP_LOCK   = 1'b0;
	localparam logic OP_UNLOCK = 1'b1;

	// result status codes
	typedef enum logic [STATUS_W-1:0] {
		ST_ACQUIRED = 3'd0,
		ST_QUEUED   = 3'd1,
		ST_FREED    = 3'd2,
		ST_HANDOFF  = 3'd3,
		ST_DROPPED  = 3'd4
	} status_t;

endpackage

[rtl/fifo_handoff_lock_manager.sv]
// queued hardware lock with a waiter ring and ownership handoff
//
// Usage: each request item carries op (0 lock, 1 unlock) and task_id. Every
// request yields exactly one result item: status, wake_task, owner_task, held.
// Both channels use valid/stall; an item moves at a clock edge where valid is
// high and stall is low.
// Path: an accepted item is held in the input register, and its result is
// then registered in the output register.
// Throughput: one item per cycle, sustained while out_stall is low. The lock state, the ring
// pointers, the front-of-queue register and a prefetched next entry are all
// updated in the same cycle, so back-to-back handoffs need no bubble; the ring
// memory's single registered read port fetches the entry behind the new head.
// Stall: while the result register holds an item that is stalled, the input
// register cannot advance and in_stall is raised once it holds an item too.
// Reset: the lock is free, owner is zero and the waiter queue is empty; the
// ring memory itself is not cleared and needs no clearing pass.
module fifo_handoff_lock_manager
	import fhlm_pkg::*;
#(
	parameter int WAITER_DEPTH = DEF_WAITER_DEPTH,
	parameter int TASK_ID_BITS = DEF_TASK_ID_BITS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                op,
	input  logic [TASK_W-1:0]   task_id,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [STATUS_W-1:0] status,
	output logic [TASK_W-1:0]   wake_task,
	output logic [TASK_W-1:0]   owner_task,
	output logic                held
);

	localparam int PTR_W = (WAITER_DEPTH > 1) ? $clog2(WAITER_DEPTH) : 1;
	localparam int CNT_W = $clog2(WAITER_DEPTH + 1);
	localparam logic [CNT_W-1:0] CntFull = CNT_W'(WAITER_DEPTH);
	localparam logic [PTR_W-1:0] PtrLast = PTR_W'(WAITER_DEPTH - 1);
	localparam logic [TASK_W-1:0] TaskMask = (TASK_ID_BITS >= TASK_W) ?
		{TASK_W{1'b1}} : TASK_W'((1 << TASK_ID_BITS) - 1);

	// ring pointer increment with wrap at the depth
	function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
		return (p == PtrLast) ? '0 : p + 1'b1;
	endfunction

	// input register
	logic              valid_s1;
	logic              op_s1;
	logic [TASK_W-1:0] task_s1;

	// lock and queue state
	logic              locked_q;
	logic [TASK_W-1:0] owner_q;
	logic [PTR_W-1:0]  head_q;
	logic [PTR_W-1:0]  tail_q;
	logic [CNT_W-1:0]  count_q;
	logic [TASK_W-1:0] front_q;

	// ring memory with registered read and write forwarding
	logic [TASK_W-1:0] ring_mem [WAITER_DEPTH];
	logic [TASK_W-1:0] rd_q;
	logic              fwd_q;
	logic [TASK_W-1:0] fwd_data_q;
	logic [TASK_W-1:0] next_entry;
	logic [PTR_W-1:0]  rd_addr;

	// result register
	logic              out_valid_q;
	status_t           status_q;
	logic [TASK_W-1:0] wake_q;
	logic [TASK_W-1:0] owner_out_q;
	logic              held_q;

	// decision logic
	logic              advance;
	logic              do_item;
	logic              push;
	logic              pop;
	status_t           status_d;
	logic              locked_d;
	logic [TASK_W-1:0] owner_d;
	logic [TASK_W-1:0] wake_d;
	logic [PTR_W-1:0]  head_d;

	// handshake
	assign advance  = !out_valid_q || !out_stall;
	assign do_item  = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;

	assign next_entry = fwd_q ? fwd_data_q : rd_q;

	// request decode against the current lock state
	always_comb begin
		push     = 1'b0;
		pop      = 1'b0;
		status_d = ST_FREED;
		locked_d = locked_q;
		owner_d  = owner_q;
		wake_d   = '0;
		if (op_s1 == OP_LOCK) begin
			if (!locked_q) begin
				status_d = ST_ACQUIRED;
				locked_d = 1'b1;
				owner_d  = task_s1;
			end else if (count_q >= CntFull) begin
				status_d = ST_DROPPED;
			end else begin
				status_d = ST_QUEUED;
				push     = do_item;
			end
		end else begin
			if (count_q == '0) begin
				status_d = ST_FREED;
				locked_d = 1'b0;
				owner_d  = '0;
			end else begin
				status_d = ST_HANDOFF;
				locked_d = 1'b1;
				owner_d  = front_q;
				wake_d   = front_q;
				pop      = do_item;
			end
		end
	end

	// head after this cycle and the prefetch address behind it
	assign head_d  = pop ? ptr_next(head_q) : head_q;
	assign rd_addr = ptr_next(head_d);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			op_s1   <= op;
			task_s1 <= task_id & TaskMask;
		end
	end

	// lock state and queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			locked_q <= 1'b0;
			owner_q  <= '0;
			head_q   <= '0;
			tail_q   <= '0;
			count_q  <= '0;
			fwd_q    <= 1'b0;
		end else begin
			fwd_q <= push && (tail_q == rd_addr);
			if (do_item) begin
				locked_q <= locked_d;
				owner_q  <= owner_d;
				head_q   <= head_d;
				if (push) begin
					tail_q  <= ptr_next(tail_q);
					count_q <= count_q + 1'b1;
				end else if (pop) begin
					count_q <= count_q - 1'b1;
				end
			end
		end
	end

	// front-of-queue register: set by a push into an empty queue, else refilled on pop
	always_ff @(posedge clk) begin
		if (push && count_q == '0) begin
			front_q <= task_s1;
		end else if (pop) begin
			front_q <= next_entry;
		end
	end

	// ring memory write at tail, prefetch read behind head
	always_ff @(posedge clk) begin
		if (push) begin
			ring_mem[tail_q] <= task_s1;
		end
		rd_q       <= ring_mem[rd_addr];
		fwd_data_q <= task_s1;
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_item) begin
			status_q    <= status_d;
			wake_q      <= wake_d;
			owner_out_q <= locked_d ? owner_d : '0;
			held_q      <= locked_d;
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign wake_task  = wake_q;
	assign owner_task = owner_out_q;
	assign held       = held_q;

	// queue count never passes the ring depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CntFull)
		else $error("waiter count above ring depth");

	// a handoff leaves the woken task as the owner
	a_handoff_owner: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && status_q == ST_HANDOFF |-> held_q && owner_out_q == wake_q)
		else $error("handoff result does not name the woken task as owner");

	// only a handoff wakes a task
	a_wake_only_handoff: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && status_q != ST_HANDOFF |-> wake_q == '0)
		else $error("wake task set on a result other than handoff");

	// a dropped request means the queue was full and stays full
	a_drop_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && status_q == ST_DROPPED |-> count_q == CntFull && locked_q)
		else $error("request dropped while the queue had room");

endmodule

[test/tb_top.sv]
// self-checking testbench for the queued lock manager with ownership handoff
module tb_top;
	import fhlm_pkg::*;

	localparam int WAITERS = DEF_WAITER_DEPTH;
	localparam int ID_BITS = DEF_TASK_ID_BITS;
	localparam logic [TASK_W-1:0] ID_MASK = TASK_W'((1 << ID_BITS) - 1);
	localparam int RANDOM_REQS = 400;
	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_CYCLES = 8;

	typedef struct {
		logic              op;
		logic [TASK_W-1:0] task_id;
	} lock_req_t;

	typedef struct {
		status_t           status;
		logic [TASK_W-1:0] wake_task;
		logic [TASK_W-1:0] owner_task;
		logic              held;
	} lock_result_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_stall;
	logic                op = OP_LOCK;
	logic [TASK_W-1:0]   task_id = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic [STATUS_W-1:0] status;
	logic [TASK_W-1:0]   wake_task;
	logic [TASK_W-1:0]   owner_task;
	logic                held;

	// requests waiting to be driven and results waiting to be seen
	lock_req_t    req_pending[$];
	lock_result_t results_due[$];
	lock_req_t    next_req;
	lock_result_t want;

	// predicted lock state
	logic              lock_taken = 1'b0;
	logic [TASK_W-1:0] lock_owner = '0;
	logic [TASK_W-1:0] waiter_q[$];
	int                deepest_wait = 0;

	int req_total = 0;
	int n_issued = 0;
	int send_idle = 37;
	int recv_stall = 46;
	int errors = 0;
	int cycles = 0;
	int status_hits[5] = '{default: 0};

	fifo_handoff_lock_manager #(
		.WAITER_DEPTH(WAITERS),
		.TASK_ID_BITS(ID_BITS)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.op(op),
		.task_id(task_id),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.wake_task(wake_task),
		.owner_task(owner_task),
		.held(held)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	function automatic void add_req(logic rq_op, logic [TASK_W-1:0] rq_task);
		lock_req_t r;
		r.op = rq_op;
		r.task_id = rq_task;
		req_pending.push_back(r);
	endfunction

	// advance the predicted lock and queue the result this request yields
	function automatic void apply_request(logic rq_op, logic [TASK_W-1:0] rq_task);
		lock_result_t r;
		logic [TASK_W-1:0] id;
		id = rq_task & ID_MASK;
		r.wake_task = '0;
		if (rq_op == OP_LOCK) begin
			if (!lock_taken) begin
				lock_taken = 1'b1;
				lock_owner = id;
				r.status = ST_ACQUIRED;
			end else if (waiter_q.size() >= WAITERS) begin
				r.status = ST_DROPPED;
			end else begin
				waiter_q.push_back(id);
				r.status = ST_QUEUED;
				if (waiter_q.size() > deepest_wait)
					deepest_wait = waiter_q.size();
			end
		end else if (waiter_q.size() == 0) begin
			lock_taken = 1'b0;
			lock_owner = '0;
			r.status = ST_FREED;
		end else begin
			// oldest waiter takes over, lock stays held
			r.wake_task = waiter_q.pop_front();
			lock_owner = r.wake_task;
			r.status = ST_HANDOFF;
		end
		r.owner_task = lock_taken ? lock_owner : '0;
		r.held = lock_taken;
		results_due.push_back(r);
	endfunction

	// request driver
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall)
				apply_request(op, task_id);
			if (!in_valid || !in_stall) begin
				if (req_pending.size() != 0 && $urandom_range(99) >= send_idle) begin
					next_req = req_pending.pop_front();
					in_valid <= 1'b1;
					op <= next_req.op;
					task_id <= next_req.task_id;
					n_issued++;
					// idling phases over thirds of the run
					case ((n_issued * 3) / req_total)
						0: begin
							send_idle <= 37;
							recv_stall <= 46;
						end
						1: begin
							send_idle <= 46;
							recv_stall <= 37;
						end
						default: begin
							send_idle <= 0;
							recv_stall <= 0;
						end
					endcase
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor and receiver stall
	always @(posedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (results_due.size() == 0) begin
					$error("result item with no request pending: status %0d", status);
					errors++;
				end else begin
					want = results_due.pop_front();
					status_hits[int'(want.status)]++;
					if (status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, status);
						errors++;
					end
					if (wake_task !== want.wake_task) begin
						$error("wake_task: expected %0d, got %0d", want.wake_task, wake_task);
						errors++;
					end
					if (owner_task !== want.owner_task) begin
						$error("owner_task: expected %0d, got %0d", want.owner_task,
							owner_task);
						errors++;
					end
					if (held !== want.held) begin
						$error("held: expected %0d, got %0d", want.held, held);
						errors++;
					end
				end
			end
			out_stall <= ($urandom_range(99) < recv_stall);
		end
	end

	// run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_top failed");
			$finish;
		end
	end

	initial begin
		int n;
		int burst_len;
		int lock_pct;
		logic [TASK_W-1:0] rid;

		// directed: free unlock, grant, self-queue, fill the ring, overflow, handoff
		add_req(OP_UNLOCK, 8'h5A);
		add_req(OP_LOCK, 8'hFF);
		add_req(OP_LOCK, 8'hFF);
		for (int i = 1; i < 16; i++)
			add_req(OP_LOCK, (i == 15) ? 8'h00 : TASK_W'(i * 17));
		add_req(OP_LOCK, 8'hA5);
		// unlock by a task that does not own the lock
		add_req(OP_UNLOCK, 8'h33);
		add_req(OP_LOCK, 8'h80);

		// random bursts, lock-heavy ones fill the ring, unlock-heavy ones drain it
		n = 0;
		while (n < RANDOM_REQS) begin
			burst_len = $urandom_range(10, 40);
			case ($urandom_range(3))
				0: lock_pct = 10;
				1: lock_pct = 50;
				2: lock_pct = 85;
				default: lock_pct = 97;
			endcase
			for (int j = 0; j < burst_len && n < RANDOM_REQS; j++) begin
				case ($urandom_range(7))
					0: rid = '0;
					1: rid = '1;
					default: rid = TASK_W'($urandom_range(255));
				endcase
				add_req(($urandom_range(99) < lock_pct) ? OP_LOCK : OP_UNLOCK, rid);
				n++;
			end
		end
		req_total = req_pending.size();

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// wait for all requests to go in and all results to come out
		while (req_pending.size() != 0 || in_valid)
			@(posedge clk);
		while (results_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d requests: %0d acquired, %0d queued, %0d freed, %0d handed off, %0d dropped",
			req_total, status_hits[ST_ACQUIRED], status_hits[ST_QUEUED],
			status_hits[ST_FREED], status_hits[ST_HANDOFF], status_hits[ST_DROPPED]);
		$display("deepest waiter queue %0d of %0d", deepest_wait, WAITERS);
		if (errors == 0 && results_due.size() == 0) begin
			$display("tb_top passed");
		end else begin
			$display("tb_top failed");
		end
		$finish;
	end

endmodule

[filelist.f]
rtl/fhlm_pkg.sv
rtl/fifo_handoff_lock_manager.sv
test/tb_top.sv
